@@ hw/rtl/odd_even_merge_sorting_network_unit_assert.svh @@
// assertion macros for the odd-even merge sorting network unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ODD_EVEN_MERGE_SORTING_NETWORK_UNIT_ASSERT_SVH
`define ODD_EVEN_MERGE_SORTING_NETWORK_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define OEMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oems assertion failed");

// next-cycle implication, checked out of reset only
`define OEMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oems assertion failed");

`endif

@@ hw/rtl/oems_pkg.sv @@
// constants and elaboration-time network builder for the sorting network
// no dependencies
package oems_pkg;

  localparam int DATA_W      = 64;
  localparam int MAX_KEYS    = 16;
  localparam int MAX_CMPS    = 128;
  localparam int STACK_DEPTH = 64;

  // work-list frame kinds
  localparam int K_SORT  = 0;
  localparam int K_MERGE = 1;
  localparam int K_TAIL  = 2;

  // query codes
  localparam int Q_NCMP    = 0;
  localparam int Q_NSTAGE  = 1;
  localparam int Q_PARTNER = 2;

  // builds the comparator list for n keys in recursion order, assigns
  // greedy stages, then answers one query
  // partner query: arg0 = stage, arg1 = position, result -1 if unused
  function automatic int oems_query(input int n, input int what, input int arg0,
                                    input int arg1);
    int lo_a [MAX_CMPS];
    int hi_a [MAX_CMPS];
    int st_a [MAX_CMPS];
    int last [MAX_KEYS];
    int fk [STACK_DEPTH];
    int fp [STACK_DEPTH];
    int fq [STACK_DEPTH];
    int fd [STACK_DEPTH];
    int fn [STACK_DEPTH];
    int fm [STACK_DEPTH];
    int ta [MAX_KEYS];
    int tb [MAX_KEYS];
    int tcnt;
    int sp;
    int ncmp;
    int nstage;
    int half;
    int hn;
    int hm;
    int k;
    int c;
    int s;
    int p;
    int q;
    int d;
    int nn;
    int mm;
    int kind;
    int res;
    ncmp = 0;
    sp = 0;
    fk[0] = K_SORT; fp[0] = 0; fq[0] = 0; fd[0] = 1; fn[0] = n; fm[0] = 0;
    sp = 1;
    while (sp > 0) begin
      sp = sp - 1;
      kind = fk[sp]; p = fp[sp]; q = fq[sp]; d = fd[sp]; nn = fn[sp]; mm = fm[sp];
      tcnt = 0;
      if (kind == K_SORT) begin
        if (nn == 2) begin
          ta[0] = p; tb[0] = p + 1; tcnt = 1;
        end else if (nn > 2 && sp + 3 <= STACK_DEPTH) begin
          half = nn - nn / 2;
          fk[sp] = K_MERGE; fp[sp] = p; fq[sp] = p + half; fd[sp] = 1;
          fn[sp] = half; fm[sp] = nn - half; sp = sp + 1;
          fk[sp] = K_SORT; fp[sp] = p + half; fq[sp] = 0; fd[sp] = 1;
          fn[sp] = nn - half; fm[sp] = 0; sp = sp + 1;
          fk[sp] = K_SORT; fp[sp] = p; fq[sp] = 0; fd[sp] = 1;
          fn[sp] = half; fm[sp] = 0; sp = sp + 1;
        end
      end else if (kind == K_MERGE) begin
        if (nn == 1 && mm == 1) begin
          ta[0] = p; tb[0] = q; tcnt = 1;
        end else if (nn != 0 && mm != 0 && sp + 3 <= STACK_DEPTH) begin
          hn = nn - nn / 2;
          hm = mm - mm / 2;
          fk[sp] = K_TAIL; fp[sp] = p; fq[sp] = q; fd[sp] = d;
          fn[sp] = nn; fm[sp] = mm; sp = sp + 1;
          fk[sp] = K_MERGE; fp[sp] = p + d; fq[sp] = q + d; fd[sp] = 2 * d;
          fn[sp] = nn - hn; fm[sp] = mm - hm; sp = sp + 1;
          fk[sp] = K_MERGE; fp[sp] = p; fq[sp] = q; fd[sp] = 2 * d;
          fn[sp] = hn; fm[sp] = hm; sp = sp + 1;
        end
      end else begin
        for (k = 1; k < nn - 1; k += 2) begin
          if (tcnt < MAX_KEYS) begin
            ta[tcnt] = p + d * k; tb[tcnt] = p + d * (k + 1); tcnt = tcnt + 1;
          end
        end
        if (nn % 2 == 0) begin
          if (tcnt < MAX_KEYS) begin
            ta[tcnt] = p + d * (nn - 1); tb[tcnt] = q; tcnt = tcnt + 1;
          end
          k = 1;
        end else begin
          k = 0;
        end
        for (; k < mm - 1; k += 2) begin
          if (tcnt < MAX_KEYS) begin
            ta[tcnt] = q + d * k; tb[tcnt] = q + d * (k + 1); tcnt = tcnt + 1;
          end
        end
      end
      for (c = 0; c < tcnt; c++) begin
        if (ncmp < MAX_CMPS && ta[c] >= 0 && tb[c] >= 0 && ta[c] < n && tb[c] < n) begin
          lo_a[ncmp] = ta[c];
          hi_a[ncmp] = tb[c];
          ncmp = ncmp + 1;
        end
      end
    end
    // greedy stage assignment keeps every wire dependence
    for (c = 0; c < MAX_KEYS; c++) begin
      last[c] = 0;
    end
    nstage = 0;
    for (c = 0; c < ncmp; c++) begin
      s = (last[lo_a[c]] > last[hi_a[c]]) ? last[lo_a[c]] : last[hi_a[c]];
      st_a[c] = s;
      last[lo_a[c]] = s + 1;
      last[hi_a[c]] = s + 1;
      if (s + 1 > nstage) begin
        nstage = s + 1;
      end
    end
    res = -1;
    if (what == Q_NCMP) begin
      res = ncmp;
    end else if (what == Q_NSTAGE) begin
      res = nstage;
    end else begin
      for (c = 0; c < ncmp; c++) begin
        if (st_a[c] == arg0) begin
          if (lo_a[c] == arg1) res = hi_a[c];
          if (hi_a[c] == arg1) res = lo_a[c];
        end
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/oems_load_stage.sv @@
// input register stage: unpacks the beat into the key vector
// depends on oems_pkg; bits past the 64-bit word read as one
module oems_load_stage #(
  parameter int NUM_KEYS  = 8,
  parameter int KEY_WIDTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [oems_pkg::DATA_W-1:0]     in_keys_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [NUM_KEYS*KEY_WIDTH-1:0]   out_keys_o
);
  import oems_pkg::*;

  localparam int VecW = NUM_KEYS * KEY_WIDTH;

  logic [VecW-1:0] ext_keys;
  logic [VecW-1:0] keys_q;
  logic            valid_q, valid_d;

  for (genvar b = 0; b < VecW; b++) begin : g_bit
    if (b < DATA_W) begin : g_in
      assign ext_keys[b] = in_keys_i[b];
    end else begin : g_fill
      assign ext_keys[b] = 1'b1;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      keys_q <= ext_keys;
    end
  end

  assign out_valid_o = valid_q;
  assign out_keys_o  = keys_q;

endmodule

@@ hw/rtl/oems_cmp_stage.sv @@
// one comparator layer of the network followed by its pipeline register
// depends on oems_pkg for the elaboration-time partner table
module oems_cmp_stage #(
  parameter int NUM_KEYS  = 8,
  parameter int KEY_WIDTH = 8,
  parameter int STAGE     = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NUM_KEYS*KEY_WIDTH-1:0] in_keys_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NUM_KEYS*KEY_WIDTH-1:0] out_keys_o
);
  import oems_pkg::*;

  localparam int VecW = NUM_KEYS * KEY_WIDTH;

  logic [VecW-1:0] layer_keys;
  logic [VecW-1:0] keys_q;
  logic            valid_q, valid_d;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_pos
    localparam int Partner = oems_query(NUM_KEYS, Q_PARTNER, STAGE, i);
    if (Partner < 0) begin : g_pass
      assign layer_keys[i*KEY_WIDTH +: KEY_WIDTH] = in_keys_i[i*KEY_WIDTH +: KEY_WIDTH];
    end else begin : g_cmp
      logic [KEY_WIDTH-1:0] own_key, other_key;
      logic                 own_lower;
      assign own_key   = in_keys_i[i*KEY_WIDTH +: KEY_WIDTH];
      assign other_key = in_keys_i[Partner*KEY_WIDTH +: KEY_WIDTH];
      assign own_lower = (own_key < other_key);
      if (i < Partner) begin : g_min
        assign layer_keys[i*KEY_WIDTH +: KEY_WIDTH] = own_lower ? own_key : other_key;
      end else begin : g_max
        assign layer_keys[i*KEY_WIDTH +: KEY_WIDTH] = own_lower ? other_key : own_key;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      keys_q <= layer_keys;
    end
  end

  assign out_valid_o = valid_q;
  assign out_keys_o  = keys_q;

endmodule

@@ hw/rtl/odd_even_merge_sorting_network_unit.sv @@
// pipeline: the load register, then a registered comparator layer for each greedy stage
// throughput: one beat per cycle while the output side is ready, each stage register holds one key vector
// stages move independently, so a bubble is squeezed out under backpressure
// reset: clears every stage valid bit, key registers are not reset
// depends on oems_pkg, oems_load_stage, oems_cmp_stage and the assert header
`include "odd_even_merge_sorting_network_unit_assert.svh"

module odd_even_merge_sorting_network_unit #(
  parameter int NUM_KEYS  = 8,
  parameter int KEY_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input beats
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [oems_pkg::DATA_W-1:0] s_axis_tdata_i,  // keys_in[63:0]
  // result beats
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [oems_pkg::DATA_W-1:0] m_axis_tdata_o   // keys_sorted[63:0]
);
  import oems_pkg::*;

  // width of the internal key vector, may exceed the 64-bit word
  localparam int VecW      = NUM_KEYS * KEY_WIDTH;
  // comparator layers built at elaboration by the batcher split and merge
  localparam int NumStages = oems_query(NUM_KEYS, Q_NSTAGE, 0, 0);
  // keys that fit entirely into the output word
  localparam int FullKeys  = (NUM_KEYS < DATA_W / KEY_WIDTH) ? NUM_KEYS : DATA_W / KEY_WIDTH;

  // register i holds the vector after i comparator layers
  logic [VecW-1:0] stage_keys  [NumStages+1];
  logic            stage_valid [NumStages+1];
  // ready seen by the output side of register i
  logic            stage_ready [NumStages+1];

  // load stage: unpack and fill the missing high bits with ones
  oems_load_stage #(
    .NUM_KEYS  (NUM_KEYS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_load (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_keys_i   (s_axis_tdata_i),
    .out_valid_o (stage_valid[0]),
    .out_ready_i (stage_ready[0]),
    .out_keys_o  (stage_keys[0])
  );

  // one registered comparator layer per greedy stage
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    oems_cmp_stage #(
      .NUM_KEYS  (NUM_KEYS),
      .KEY_WIDTH (KEY_WIDTH),
      .STAGE     (s)
    ) u_cmp (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stage_valid[s]),
      .in_ready_o  (stage_ready[s]),
      .in_keys_i   (stage_keys[s]),
      .out_valid_o (stage_valid[s+1]),
      .out_ready_i (stage_ready[s+1]),
      .out_keys_o  (stage_keys[s+1])
    );
  end

  // last register doubles as the output register
  assign stage_ready[NumStages] = m_axis_tready_i;
  assign m_axis_tvalid_o        = stage_valid[NumStages];

  // sorted positions above bit 63 are dropped, unused high bits read zero
  if (VecW >= DATA_W) begin : g_out_trunc
    assign m_axis_tdata_o = stage_keys[NumStages][DATA_W-1:0];
  end else begin : g_out_ext
    assign m_axis_tdata_o = {{(DATA_W-VecW){1'b0}}, stage_keys[NumStages]};
  end

  // ascending order check over the keys that are whole in the output word
  logic [FullKeys-1:0] order_ok;
  assign order_ok[FullKeys-1] = 1'b1;
  for (genvar i = 0; i < FullKeys - 1; i++) begin : g_order
    assign order_ok[i] = (m_axis_tdata_o[i*KEY_WIDTH +: KEY_WIDTH]
                          <= m_axis_tdata_o[(i+1)*KEY_WIDTH +: KEY_WIDTH]);
  end

  // an empty output register never blocks the input side
  `OEMS_ASSERT_IMPL(a_ready_when_drained, !m_axis_tvalid_o, s_axis_tready_o)
  // an accepted beat always lands in the load register
  `OEMS_ASSERT_NEXT(a_accept_lands, s_axis_tvalid_i && s_axis_tready_o, stage_valid[0])
  // every result beat leaves the network with its whole keys in ascending order
  `OEMS_ASSERT_IMPL(a_out_sorted, m_axis_tvalid_o, &order_ok)

endmodule
